// File: sv/port_switch_debouncer_top_assert.svh
// Assertion macros for the port switch debouncer, used by psd_merge.
`ifndef PORT_SWITCH_DEBOUNCER_TOP_ASSERT_SVH
`define PORT_SWITCH_DEBOUNCER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high.
`define PSD_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("port switch debouncer: check failed");
// Next-cycle implication, disabled while reset is high.
`define PSD_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("port switch debouncer: check failed");
`else
`define PSD_ASSERT_IMP(name, clk, rst, ante, cons)
`define PSD_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// File: sv/psd_pkg.sv
// Types, register codes and helpers for the port switch debouncer.
package psd_pkg;

  // Width of the sampled port; pins at or above this index are never debounced.
  localparam int PORT_BITS = 8;

  // Configuration register indices.
  localparam logic [2:0] REG_BOUNCE_DELAY = 3'd0;
  localparam logic [2:0] REG_ENABLE       = 3'd1;
  localparam logic [2:0] REG_INVERT       = 3'd2;
  localparam logic [2:0] REG_FAST         = 3'd3;
  localparam logic [2:0] REG_SKIP_RISE    = 3'd4;
  localparam logic [2:0] REG_SKIP_FALL    = 3'd5;
  localparam logic [2:0] REG_PORT_LABEL   = 3'd6;

  // Reset values of the non-zero registers ('Z' is the default port label).
  localparam logic [15:0] BOUNCE_DELAY_RESET = 16'd50;
  localparam logic [7:0]  PORT_LABEL_RESET   = 8'd90;

  // Per-pin configuration bits handed to a lane.
  typedef struct packed {
    logic enable;
    logic invert;
    logic fast;
    logic skip_rise;
    logic skip_fall;
  } pin_cfg_t;

  // What a lane found for the current beat.
  typedef struct packed {
    logic hit;
    logic level;
  } lane_rpt_t;

  // Index of the lowest set bit of a port-wide mask.
  function automatic logic [2:0] lowest_index(input logic [PORT_BITS-1:0] m);
    logic [2:0] idx;
    idx = '0;
    for (int i = PORT_BITS - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: sv/psd_if.sv
// Valid/ready channel interfaces for port samples and edge reports.
interface psd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  sample;
  logic [31:0] time_now;

  modport source (output valid, output sample, output time_now, input ready);
  modport sink (input valid, input sample, input time_now, output ready);
endinterface

interface psd_out_if;
  logic       valid;
  logic       ready;
  logic       level;
  logic [2:0] pin_index;
  logic [7:0] port_id;
  logic       last;

  modport source (output valid, output level, output pin_index, output port_id,
                  output last, input ready);
  modport sink (input valid, input level, input pin_index, input port_id,
                input last, output ready);
endinterface

// File: sv/port_switch_debouncer_top.sv
// Port switch debouncer: per-pin debounce lanes, configuration and report merge.
// Each input beat carries one sample of an 8-bit port and the millisecond time;
// every enabled pin runs its own lane, which accepts a new level once it differs
// from the stable one and more than bounce_delay ms have passed since the last
// transient change (32-bit wrapping difference). Accepted, unsuppressed edges
// leave as one report beat each, in increasing pin order, with last set on the
// final report of the sample; a sample with no edge gives no beat. All lanes
// evaluate a sample in the cycle it is taken, so a sample giving zero or one
// report is followed by the next in the following cycle if the output is free;
// one giving several reports (up to eight) holds the next back until its last is
// loaded; reports pass the pending set, then the single-report output register.
module port_switch_debouncer_top #(
  parameter int PIN_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data,
  psd_in_if.sink      samples,
  psd_out_if.source   reports
);

  localparam int LANES = (PIN_COUNT < psd_pkg::PORT_BITS) ? PIN_COUNT : psd_pkg::PORT_BITS;

  logic [15:0] bounce_delay;
  logic [7:0]  enable_mask;
  logic [7:0]  invert_mask;
  logic [7:0]  fast_mask;
  logic [7:0]  skip_rise_mask;
  logic [7:0]  skip_fall_mask;
  logic [7:0]  port_label;

  logic                          take;
  logic                          merge_ready;
  logic [psd_pkg::PORT_BITS-1:0] hits;
  logic [psd_pkg::PORT_BITS-1:0] levels;

  // Configuration registers; unknown indices are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      bounce_delay   <= psd_pkg::BOUNCE_DELAY_RESET;
      enable_mask    <= '0;
      invert_mask    <= '0;
      fast_mask      <= '0;
      skip_rise_mask <= '0;
      skip_fall_mask <= '0;
      port_label     <= psd_pkg::PORT_LABEL_RESET;
    end else if (wr_en) begin
      case (wr_index)
        psd_pkg::REG_BOUNCE_DELAY: bounce_delay   <= wr_data;
        psd_pkg::REG_ENABLE:       enable_mask    <= wr_data[7:0];
        psd_pkg::REG_INVERT:       invert_mask    <= wr_data[7:0];
        psd_pkg::REG_FAST:         fast_mask      <= wr_data[7:0];
        psd_pkg::REG_SKIP_RISE:    skip_rise_mask <= wr_data[7:0];
        psd_pkg::REG_SKIP_FALL:    skip_fall_mask <= wr_data[7:0];
        psd_pkg::REG_PORT_LABEL:   port_label     <= wr_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Input handshake.
  assign samples.ready = merge_ready;
  assign take          = samples.valid && merge_ready;

  // Debounce lanes, one per pin below PIN_COUNT; pins without a lane never report.
  for (genvar i = 0; i < psd_pkg::PORT_BITS; i++) begin : g_pin
    if (i < LANES) begin : g_lane
      psd_pkg::pin_cfg_t  cfg;
      psd_pkg::lane_rpt_t rpt;

      assign cfg.enable    = enable_mask[i];
      assign cfg.invert    = invert_mask[i];
      assign cfg.fast      = fast_mask[i];
      assign cfg.skip_rise = skip_rise_mask[i];
      assign cfg.skip_fall = skip_fall_mask[i];

      psd_lane u_lane (
        .clk          (clk),
        .rst          (rst),
        .take         (take),
        .pin          (samples.sample[i]),
        .time_now     (samples.time_now),
        .bounce_delay (bounce_delay),
        .cfg          (cfg),
        .rpt          (rpt)
      );

      assign hits[i]   = rpt.hit;
      assign levels[i] = rpt.level;
    end else begin : g_none
      assign hits[i]   = 1'b0;
      assign levels[i] = 1'b0;
    end
  end

  // Serialise the lane hits into report beats.
  psd_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .hits    (hits),
    .levels  (levels),
    .label   (port_label),
    .ready   (merge_ready),
    .reports (reports)
  );

endmodule

// File: sv/psd_lane.sv
// One debounce lane: state and acceptance test for a single port pin.
module psd_lane (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic               pin,
  input  logic [31:0]        time_now,
  input  logic [15:0]        bounce_delay,
  input  psd_pkg::pin_cfg_t  cfg,
  output psd_pkg::lane_rpt_t rpt
);

  logic        stable;
  logic        transient;
  logic [31:0] change_time;
  logic [31:0] elapsed;
  logic        accept;
  logic        rep;

  // Elapsed time since the last transient change, wrapping modulo 2^32.
  assign elapsed = time_now - change_time;

  // A new level is taken once it has held long enough. Outside fast mode a
  // level that differs from the transient one restarts the timer first, so
  // it can never pass in the same beat.
  assign accept = cfg.enable && (pin != stable) && (cfg.fast || (pin == transient))
                  && (elapsed > {16'd0, bounce_delay});

  // Reported level and per-direction suppression.
  assign rep       = pin ^ cfg.invert;
  assign rpt.level = rep;
  assign rpt.hit   = accept && (rep ? !cfg.skip_rise : !cfg.skip_fall);

  // Pin state; a disabled pin keeps its state untouched.
  always_ff @(posedge clk) begin
    if (rst) begin
      stable      <= 1'b0;
      transient   <= 1'b0;
      change_time <= '0;
    end else if (take && cfg.enable) begin
      if (accept) begin
        stable <= pin;
      end
      if (pin != transient) begin
        transient   <= pin;
        change_time <= time_now;
      end
    end
  end

endmodule

// File: sv/psd_merge.sv
// Merging stage: holds one beat's lane hits and sends them out in pin order.
`include "port_switch_debouncer_top_assert.svh"
module psd_merge (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  logic [psd_pkg::PORT_BITS-1:0]  hits,
  input  logic [psd_pkg::PORT_BITS-1:0]  levels,
  input  logic [7:0]                     label,
  output logic                           ready,
  psd_out_if.source                      reports
);

  logic [psd_pkg::PORT_BITS-1:0] pend_mask;
  logic [psd_pkg::PORT_BITS-1:0] pend_level;
  logic [7:0]                    pend_label;
  logic [psd_pkg::PORT_BITS-1:0] rest;
  logic [2:0]                    pick;
  logic                          out_free;
  logic                          out_load;

  // Lowest pending pin goes next; the rest stays behind.
  assign rest     = pend_mask & (pend_mask - 1'b1);
  assign pick     = psd_pkg::lowest_index(pend_mask);
  assign out_free = !reports.valid || reports.ready;
  assign out_load = (pend_mask != '0) && out_free;

  // A new beat may enter once the pending set is empty or leaves this cycle.
  assign ready = (pend_mask == '0) || ((rest == '0) && out_free);

  // Pending hit set.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_mask <= '0;
    end else if (take) begin
      pend_mask <= hits;
    end else if (out_load) begin
      pend_mask <= rest;
    end
  end

  // Levels and label of the pending beat.
  always_ff @(posedge clk) begin
    if (take) begin
      pend_level <= levels;
      pend_label <= label;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      reports.valid <= 1'b0;
    end else if (out_load) begin
      reports.valid <= 1'b1;
    end else if (reports.ready) begin
      reports.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      reports.level     <= pend_level[pick];
      reports.pin_index <= pick;
      reports.port_id   <= pend_label;
      reports.last      <= (rest == '0);
    end
  end

  // A beat never overwrites reports that have not all moved on.
  `PSD_ASSERT_IMP(a_take_no_backlog, clk, rst, take, rest == '0)
  `PSD_ASSERT_IMP(a_take_out_free, clk, rst, take && (pend_mask != '0), out_free)
  // The pending set is exactly the hits of the beat just taken.
  `PSD_ASSERT_NEXT(a_take_loads, clk, rst, take, pend_mask == $past(hits))
  // A report only appears when something was pending.
  `PSD_ASSERT_IMP(a_out_from_pend, clk, rst, $rose(reports.valid), $past(pend_mask != '0))

endmodule
